/* rtl/lfr_pkg.sv */
// Shared types, widths and command codes for the line fit residual block.
`timescale 1ns / 1ps

package lfr_pkg;

    // Coordinate format, signed Q11.8 in units of 1/256 mm.
    localparam int COORD_W = 20;
    localparam int RES_MAX = 524287;
    localparam int RES_MIN = -524288;

    // Internal widths, sized for the largest supported plane count of eight.
    localparam int SUM_W  = 24;   // sum of z, x or y
    localparam int SQ_W   = 44;   // sum of z*z, z*x or z*y
    localparam int SDV_W  = 50;   // scaled covariance terms Sdd, Sdx, Sdy
    localparam int HALF_W = 25;   // low half of a covariance term
    localparam int DIFF_W = 25;   // n*v - sum_v
    localparam int OP_W   = 26;   // multiplier operand
    localparam int PROD_W = 52;   // multiplier product
    localparam int NUM_W  = 76;   // residual numerator
    localparam int DEN_W  = 52;   // residual denominator n*Sdd
    localparam int QUO_W  = 23;   // quotient magnitude bits, the residual stays below 2^22
    localparam int STEP_W = 5;    // step counter for numerator and divider sequences
    localparam int NUM_STEPS = 5; // multiply-accumulate steps per numerator

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
        logic                      skip_event;
    } lfr_hit_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] res_x;
        logic signed [COORD_W-1:0] res_y;
        logic [1:0]                plane_index;
        logic                      fit_failed;
        logic                      last_of_event;
    } lfr_res_t;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [3:0] {
        MUL_NONE  = 4'd0,
        MUL_ZZ    = 4'd1,
        MUL_ZX    = 4'd2,
        MUL_ZY    = 4'd3,
        MUL_SQ    = 4'd4,
        MUL_SZX   = 4'd5,
        MUL_SZY   = 4'd6,
        MUL_DZ_LO = 4'd7,
        MUL_DZ_HI = 4'd8,
        MUL_DV_LO = 4'd9,
        MUL_DV_HI = 4'd10
    } lfr_mul_sel_t;

    // What the datapath does with the registered product.
    typedef enum logic [3:0] {
        ACC_NONE    = 4'd0,
        ACC_ZZ      = 4'd1,
        ACC_ZX      = 4'd2,
        ACC_ZY      = 4'd3,
        ACC_SDD     = 4'd4,
        ACC_SDVX    = 4'd5,
        ACC_SDVY    = 4'd6,
        ACC_NUM_CLR = 4'd7,
        ACC_ADD_LO  = 4'd8,
        ACC_ADD_HI  = 4'd9,
        ACC_SUB_LO  = 4'd10,
        ACC_SUB_HI  = 4'd11
    } lfr_acc_op_t;

    typedef struct packed {
        lfr_mul_sel_t mul_sel;
        lfr_acc_op_t  acc_op;
        logic         load_hit;
        logic         clear_sums;
        logic         rd_en;
        logic         diff_load;
        logic         div_init;
        logic         div_step;
        logic         rnd_store;
        logic         chan;
        logic         out_load;
        logic         out_last;
    } lfr_cmd_t;

    typedef struct packed {
        logic fit_failed;
    } lfr_sts_t;

endpackage

/* rtl/four_plane_line_fit_residuals.sv */
// Top level of the straight line track fit residual block.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_hit (lfr_hit_t): hit_x, hit_y, hit_z, skip_event
//   m_        out        m_valid / m_ready  m_res (lfr_res_t): res_x, res_y, plane_index,
//                                           fit_failed, last_of_event
//
// A hit beat is accepted and then the shared 26x26 multiplier forms z*z, z*x and z*y
// for the running sums; no new hit is accepted until it is back in idle.
// After the last plane of a good event, the fit is set up; then each plane goes through
// read, differences, per coordinate 5 multiply steps, divider init, the divider steps
// and a rounding step, then its output beat, bounded by the one-bit-per-cycle divider.
// A failed fit goes from the differences straight to the output beat. A skipped event ends right after its last hit.
// Reset (aresetn, synchronous, active low) clears the controller and the sums.
// A stalled result beat holds in the output register and the next result waits behind it;
// input beats are taken only in idle, and are still taken while an event's last beat waits.
`timescale 1ns / 1ps

module four_plane_line_fit_residuals
    import lfr_pkg::*;
#(
    parameter int NUM_PLANES = 4
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lfr_hit_t s_hit,
    output logic     m_valid,
    input  logic     m_ready,
    output lfr_res_t m_res
);

    localparam int IDX_W = $clog2(NUM_PLANES);

    lfr_cmd_t         cmd;
    lfr_sts_t         sts;
    logic [IDX_W-1:0] idx;

    // The controller owns the handshakes, the plane counter and the skip flag.
    lfr_ctrl #(
        .NUM_PLANES(NUM_PLANES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_skip  (s_hit.skip_event),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd),
        .idx     (idx)
    );

    // The datapath holds the hits, the sums, the multiplier, the divider and the
    // output register.
    lfr_datapath #(
        .NUM_PLANES(NUM_PLANES)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_hit   (s_hit),
        .cmd     (cmd),
        .idx     (idx),
        .sts     (sts),
        .m_res   (m_res)
    );

endmodule

/* rtl/lfr_datapath.sv */
// Datapath: hit store, running sums, shared multiplier, numerator and divider.
`timescale 1ns / 1ps

module lfr_datapath
    import lfr_pkg::*;
#(
    parameter int NUM_PLANES = 4,
    localparam int IDX_W = $clog2(NUM_PLANES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lfr_hit_t         s_hit,
    input  lfr_cmd_t         cmd,
    input  logic [IDX_W-1:0] idx,
    output lfr_sts_t         sts,
    output lfr_res_t         m_res
);

    localparam logic signed [4:0] NP = 5'(NUM_PLANES);

    logic [3*COORD_W-1:0] hit_mem [NUM_PLANES];
    logic [3*COORD_W-1:0] rd_data_reg;

    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic signed [SUM_W-1:0]   sum_z_reg, sum_x_reg, sum_y_reg;
    logic signed [SQ_W-1:0]    szz_reg, szx_reg, szy_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SDV_W-1:0]   sdd_reg, sdvx_reg, sdvy_reg, sd_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic                      fail_reg;
    logic signed [DIFF_W-1:0]  dz_reg, dvx_reg, dvy_reg, dz_next, dvx_next, dvy_next;
    logic signed [NUM_W-1:0]   num_reg, prod_ext;
    logic                      neg_reg;
    logic [NUM_W-1:0]          mag_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]          quo_reg;
    logic [DEN_W:0]            trial, trial_sub;
    logic                      trial_ge, half_up;
    logic [QUO_W:0]            qr, qr_neg;
    logic signed [COORD_W-1:0] resx_reg, resy_reg, res_next;
    lfr_res_t                  out_reg;

    logic signed [OP_W-1:0]    mul_a, mul_b;
    logic signed [SDV_W-1:0]   sdv_sel;
    logic signed [DIFF_W-1:0]  dv_sel;
    logic signed [SQ_W-1:0]    sq_base;
    logic signed [DEN_W:0]     den_wide;

    assign sdv_sel = cmd.chan ? sdvy_reg : sdvx_reg;
    assign dv_sel  = cmd.chan ? dvy_reg : dvx_reg;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_ZZ: begin
                mul_a = OP_W'(z_reg);
                mul_b = OP_W'(z_reg);
            end
            MUL_ZX: begin
                mul_a = OP_W'(z_reg);
                mul_b = OP_W'(x_reg);
            end
            MUL_ZY: begin
                mul_a = OP_W'(z_reg);
                mul_b = OP_W'(y_reg);
            end
            MUL_SQ: begin
                mul_a = OP_W'(sum_z_reg);
                mul_b = OP_W'(sum_z_reg);
            end
            MUL_SZX: begin
                mul_a = OP_W'(sum_z_reg);
                mul_b = OP_W'(sum_x_reg);
            end
            MUL_SZY: begin
                mul_a = OP_W'(sum_z_reg);
                mul_b = OP_W'(sum_y_reg);
            end
            MUL_DZ_LO: begin
                mul_a = OP_W'(dz_reg);
                mul_b = OP_W'($signed({1'b0, sdv_sel[HALF_W-1:0]}));
            end
            MUL_DZ_HI: begin
                mul_a = OP_W'(dz_reg);
                mul_b = OP_W'($signed(sdv_sel[SDV_W-1:HALF_W]));
            end
            MUL_DV_LO: begin
                mul_a = OP_W'(dv_sel);
                mul_b = OP_W'($signed({1'b0, sdd_reg[HALF_W-1:0]}));
            end
            MUL_DV_HI: begin
                mul_a = OP_W'(dv_sel);
                mul_b = OP_W'($signed(sdd_reg[SDV_W-1:HALF_W]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_ext  = NUM_W'(prod_reg);

    // Scaled covariance: n * (n * sum_zv - sum_z * sum_v), product already registered.
    always_comb begin
        unique case (cmd.acc_op)
            ACC_SDVX: sq_base = szx_reg;
            ACC_SDVY: sq_base = szy_reg;
            default:  sq_base = szz_reg;
        endcase
    end
    assign sd_next = SDV_W'(NP * (SDV_W'(NP * SDV_W'(sq_base)) - SDV_W'(prod_reg)));

    assign den_wide = (DEN_W+1)'(sdd_reg) * (DEN_W+1)'(NP);
    assign den_next = den_wide[DEN_W-1:0];

    assign dz_next  = DIFF_W'(NP * DIFF_W'($signed(rd_data_reg[COORD_W-1:0])))
                      - DIFF_W'(sum_z_reg);
    assign dvx_next = DIFF_W'(NP * DIFF_W'($signed(rd_data_reg[3*COORD_W-1:2*COORD_W])))
                      - DIFF_W'(sum_x_reg);
    assign dvy_next = DIFF_W'(NP * DIFF_W'($signed(rd_data_reg[2*COORD_W-1:COORD_W])))
                      - DIFF_W'(sum_y_reg);

    // Restoring division, one quotient bit per cycle.
    assign mag_next  = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign trial     = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign rem_next  = trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    // Round half away from zero on the magnitude, then saturate with the sign.
    assign half_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign qr      = {1'b0, quo_reg} + (QUO_W+1)'(half_up);
    assign qr_neg  = ~qr + (QUO_W+1)'(1);

    always_comb begin
        if (!neg_reg) begin
            res_next = (qr > (QUO_W+1)'(RES_MAX)) ? COORD_W'(RES_MAX) : COORD_W'(qr);
        end else begin
            res_next = (qr > (QUO_W+1)'(-RES_MIN)) ? COORD_W'(RES_MIN) : COORD_W'(qr_neg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hit) begin
            hit_mem[idx] <= {s_hit.hit_x, s_hit.hit_y, s_hit.hit_z};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= hit_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_z_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            szz_reg   <= '0;
            szx_reg   <= '0;
            szy_reg   <= '0;
        end else if (cmd.clear_sums) begin
            sum_z_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            szz_reg   <= '0;
            szx_reg   <= '0;
            szy_reg   <= '0;
        end else begin
            if (cmd.load_hit) begin
                sum_z_reg <= sum_z_reg + SUM_W'(s_hit.hit_z);
                sum_x_reg <= sum_x_reg + SUM_W'(s_hit.hit_x);
                sum_y_reg <= sum_y_reg + SUM_W'(s_hit.hit_y);
            end
            if (cmd.acc_op == ACC_ZZ) szz_reg <= szz_reg + SQ_W'(prod_reg);
            if (cmd.acc_op == ACC_ZX) szx_reg <= szx_reg + SQ_W'(prod_reg);
            if (cmd.acc_op == ACC_ZY) szy_reg <= szy_reg + SQ_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.load_hit) begin
            x_reg <= s_hit.hit_x;
            y_reg <= s_hit.hit_y;
            z_reg <= s_hit.hit_z;
        end
        if (cmd.acc_op == ACC_SDD)  sdd_reg  <= sd_next;
        if (cmd.acc_op == ACC_SDVX) sdvx_reg <= sd_next;
        if (cmd.acc_op == ACC_SDVY) begin
            sdvy_reg <= sd_next;
            den_reg  <= den_next;
            fail_reg <= (sdd_reg == '0);
        end
        if (cmd.diff_load) begin
            dz_reg  <= dz_next;
            dvx_reg <= dvx_next;
            dvy_reg <= dvy_next;
        end
        unique case (cmd.acc_op)
            ACC_NUM_CLR: num_reg <= '0;
            ACC_ADD_LO:  num_reg <= num_reg + prod_ext;
            ACC_ADD_HI:  num_reg <= num_reg + (prod_ext <<< HALF_W);
            ACC_SUB_LO:  num_reg <= num_reg - prod_ext;
            ACC_SUB_HI:  num_reg <= num_reg - (prod_ext <<< HALF_W);
            default: ;
        endcase
        if (cmd.div_init) begin
            neg_reg <= num_reg[NUM_W-1];
            rem_reg <= mag_next[QUO_W+DEN_W-1:QUO_W];
            quo_reg <= mag_next[QUO_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], trial_ge};
        end
        if (cmd.rnd_store) begin
            if (cmd.chan) resy_reg <= res_next;
            else          resx_reg <= res_next;
        end
        if (cmd.out_load) begin
            out_reg.res_x         <= fail_reg ? '0 : resx_reg;
            out_reg.res_y         <= fail_reg ? '0 : resy_reg;
            out_reg.plane_index   <= idx[1:0];
            out_reg.fit_failed    <= fail_reg;
            out_reg.last_of_event <= cmd.out_last;
        end
    end

    assign sts.fit_failed = fail_reg;
    assign m_res          = out_reg;

endmodule

/* rtl/lfr_ctrl.sv */
// Controller: sequences accumulation, fit setup, residual arithmetic and output beats.
`timescale 1ns / 1ps

module lfr_ctrl
    import lfr_pkg::*;
#(
    parameter int NUM_PLANES = 4,
    localparam int IDX_W = $clog2(NUM_PLANES)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_skip,
    output logic             m_valid,
    input  logic             m_ready,
    input  lfr_sts_t         sts,
    output lfr_cmd_t         cmd,
    output logic [IDX_W-1:0] idx
);

    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_PLANES - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] NUM_LAST = STEP_W'(NUM_STEPS - 1);

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_MZZ   = 16'h0002,
        ST_MZX   = 16'h0004,
        ST_MZY   = 16'h0008,
        ST_AZY   = 16'h0010,
        ST_SQ    = 16'h0020,
        ST_SDD   = 16'h0040,
        ST_SDVX  = 16'h0080,
        ST_SDVY  = 16'h0100,
        ST_RD    = 16'h0200,
        ST_DIFF  = 16'h0400,
        ST_NUM   = 16'h0800,
        ST_DINIT = 16'h1000,
        ST_DIV   = 16'h2000,
        ST_RND   = 16'h4000,
        ST_EMIT  = 16'h8000
    } lfr_state_t;

    lfr_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              chan_reg, chan_next;
    logic              skip_reg, skip_next;
    logic              mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        chan_next   = chan_reg;
        skip_next   = skip_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        cmd.mul_sel = MUL_NONE;
        cmd.acc_op  = ACC_NONE;
        cmd.chan    = chan_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_hit = 1'b1;
                    skip_next    = skip_reg | s_skip;
                    state_next   = ST_MZZ;
                end
            end
            ST_MZZ: begin
                cmd.mul_sel = MUL_ZZ;
                state_next  = ST_MZX;
            end
            ST_MZX: begin
                cmd.acc_op  = ACC_ZZ;
                cmd.mul_sel = MUL_ZX;
                state_next  = ST_MZY;
            end
            ST_MZY: begin
                cmd.acc_op  = ACC_ZX;
                cmd.mul_sel = MUL_ZY;
                state_next  = ST_AZY;
            end
            ST_AZY: begin
                cmd.acc_op = ACC_ZY;
                if (cnt_reg != LAST_IDX) begin
                    cnt_next   = cnt_reg + IDX_W'(1);
                    state_next = ST_IDLE;
                end else if (skip_reg) begin
                    // The z*y product lands this cycle, but the clear wins and drops it.
                    cmd.clear_sums = 1'b1;
                    cnt_next       = '0;
                    skip_next      = 1'b0;
                    state_next     = ST_IDLE;
                end else begin
                    cnt_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_sel = MUL_SQ;
                state_next  = ST_SDD;
            end
            ST_SDD: begin
                cmd.acc_op  = ACC_SDD;
                cmd.mul_sel = MUL_SZX;
                state_next  = ST_SDVX;
            end
            ST_SDVX: begin
                cmd.acc_op  = ACC_SDVX;
                cmd.mul_sel = MUL_SZY;
                state_next  = ST_SDVY;
            end
            ST_SDVY: begin
                cmd.acc_op = ACC_SDVY;
                state_next = ST_RD;
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff_load = 1'b1;
                chan_next     = 1'b0;
                step_next     = '0;
                state_next    = sts.fit_failed ? ST_EMIT : ST_NUM;
            end
            ST_NUM: begin
                priority if (step_reg == STEP_W'(0)) begin
                    cmd.acc_op  = ACC_NUM_CLR;
                    cmd.mul_sel = MUL_DZ_LO;
                end else if (step_reg == STEP_W'(1)) begin
                    cmd.acc_op  = ACC_ADD_LO;
                    cmd.mul_sel = MUL_DZ_HI;
                end else if (step_reg == STEP_W'(2)) begin
                    cmd.acc_op  = ACC_ADD_HI;
                    cmd.mul_sel = MUL_DV_LO;
                end else if (step_reg == STEP_W'(3)) begin
                    cmd.acc_op  = ACC_SUB_LO;
                    cmd.mul_sel = MUL_DV_HI;
                end else begin
                    cmd.acc_op  = ACC_SUB_HI;
                end
                if (step_reg == NUM_LAST) begin
                    step_next  = '0;
                    state_next = ST_DINIT;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = ST_RND;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_RND: begin
                cmd.rnd_store = 1'b1;
                if (!chan_reg) begin
                    chan_next  = 1'b1;
                    state_next = ST_NUM;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (cnt_reg == LAST_IDX);
                    mvalid_next  = 1'b1;
                    if (cnt_reg == LAST_IDX) begin
                        cmd.clear_sums = 1'b1;
                        cnt_next       = '0;
                        skip_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            step_reg   <= '0;
            chan_reg   <= 1'b0;
            skip_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            chan_reg   <= chan_next;
            skip_reg   <= skip_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;
    assign idx     = cnt_reg;

    // An accepted hit always occupies the multiplier for the following cycles.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted again right after a hit");

    // A pending output beat is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!mvalid_reg || m_ready))
        else $error("output register loaded while its beat is still pending");

    // After the final residual of an event the controller is back at plane zero.
    a_event_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_last) |=> (state_reg == ST_IDLE && cnt_reg == '0))
        else $error("event did not close after its last residual");

    // The divider never runs past its quotient width.
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (step_reg <= DIV_LAST))
        else $error("divider step counter out of range");

endmodule

/* dv/four_plane_line_fit_residuals_test.sv */
// Self-checking testbench for the four plane straight line fit residual block.
`timescale 1ns / 1ps

module four_plane_line_fit_residuals_test;
    import lfr_pkg::*;

    localparam int PLANES = 4;
    // Idle limit: covers a full good event plus long receiver stalls.
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_HITS = 500;
    localparam int DIRECTED_ROWS = 24;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    lfr_hit_t s_hit;
    logic     m_valid;
    logic     m_ready;
    lfr_res_t m_res;

    four_plane_line_fit_residuals #(.NUM_PLANES(PLANES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_hit(s_hit),
        .m_valid(m_valid), .m_ready(m_ready), .m_res(m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Predictor state: one event's hits collected until the last plane arrives.
    lfr_hit_t event_hits[PLANES];
    int       hits_in_event;
    logic     event_skipped;
    lfr_res_t residual_queue[$];
    int       error_count;
    int       idle_cycles;
    int       beat_count;
    bit       stimulus_done;
    bit       hold_off;       // long receiver stall requested by the sender thread
    bit       quiet_phase;    // stretch with no random idling

    // Round num/den to nearest, ties away from zero, then saturate to 20 bits.
    function automatic logic signed [19:0] round_saturate(logic signed [127:0] num,
                                                          logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] quo;
        logic signed [127:0] rem;
        mag = (num < 0) ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if (rem >= den - rem) quo = quo + 1;
        if (num < 0) quo = -quo;
        if (quo > RES_MAX) return 20'sd524287;
        if (quo < RES_MIN) return -20'sd524288;
        return quo[19:0];
    endfunction

    // Fit x and y against z over the finished event and queue one residual per plane.
    task automatic fit_event();
        logic signed [127:0] n, sz, szz, sv[2], szv[2], sdd, sdv[2], dz, dv, r;
        lfr_res_t res;
        n = PLANES;
        sz = 0; szz = 0;
        for (int c = 0; c < 2; c++) begin
            sv[c] = 0; szv[c] = 0;
        end
        for (int k = 0; k < PLANES; k++) begin
            sz  += event_hits[k].hit_z;
            szz += event_hits[k].hit_z * event_hits[k].hit_z;
            sv[0] += event_hits[k].hit_x;
            sv[1] += event_hits[k].hit_y;
            szv[0] += event_hits[k].hit_z * event_hits[k].hit_x;
            szv[1] += event_hits[k].hit_z * event_hits[k].hit_y;
        end
        sdd = n * (n * szz - sz * sz);
        for (int c = 0; c < 2; c++) sdv[c] = n * (n * szv[c] - sz * sv[c]);
        for (int k = 0; k < PLANES; k++) begin
            dz = n * event_hits[k].hit_z - sz;
            res = '0;
            for (int c = 0; c < 2; c++) begin
                if (sdd > 0) begin
                    dv = n * ((c == 0) ? event_hits[k].hit_x : event_hits[k].hit_y) - sv[c];
                    r = round_saturate(dz * sdv[c] - dv * sdd, n * sdd);
                    if (c == 0) res.res_x = r[19:0];
                    else        res.res_y = r[19:0];
                end
            end
            res.plane_index   = k[1:0];
            res.fit_failed    = (sdd > 0) ? 1'b0 : 1'b1;
            res.last_of_event = (k == PLANES - 1);
            residual_queue.insert(residual_queue.size(), res);
        end
    endtask

    task automatic predict_hit(lfr_hit_t h);
        event_hits[hits_in_event] = h;
        if (h.skip_event) event_skipped = 1'b1;
        if (hits_in_event + 1 < PLANES) begin
            hits_in_event++;
        end else begin
            if (!event_skipped) fit_event();
            hits_in_event = 0;
            event_skipped = 1'b0;
        end
    endtask

    // Offer one hit beat, optionally after a random gap, and wait for acceptance.
    // Valid stays high after acceptance so that back to back beats need no second
    // assignment in the accepting cycle.
    task automatic send_hit(lfr_hit_t h);
        if (!quiet_phase) begin
            while ($urandom_range(99) < 15) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_hit   <= h;
        do @(posedge aclk); while (!s_ready);
        predict_hit(h);
    endtask

    // Drop valid after the last accepted beat before the sender waits.
    task automatic pause_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic lfr_hit_t make_hit(int x, int y, int z, bit skip);
        lfr_hit_t h;
        h.hit_x = x[19:0];
        h.hit_y = y[19:0];
        h.hit_z = z[19:0];
        h.skip_event = skip;
        return h;
    endfunction

    function automatic logic [19:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            default: return $urandom_range(0, 8191) - 4096;
        endcase
    endfunction

    // Directed rows: plane hits, with a known residual pattern where it is obvious.
    typedef struct {
        lfr_hit_t hit;
    } hit_row_t;
    hit_row_t directed_rows[DIRECTED_ROWS];

    task automatic load_directed_rows();
        int i;
        i = 0;
        // All z equal: degenerate fit, residuals zero and fit_failed.
        for (int k = 0; k < PLANES; k++) directed_rows[i++].hit = make_hit(100 * k, -50, 777, 0);
        // Points on a line: residuals all zero.
        for (int k = 0; k < PLANES; k++)
            directed_rows[i++].hit = make_hit(256 * k, -512 * k, 1024 * k, 0);
        // Skip on one middle hit: no results for the event.
        for (int k = 0; k < PLANES; k++)
            directed_rows[i++].hit = make_hit(k, k, k * 10, k == 2);
        // Field extremes, forcing saturation.
        directed_rows[i++].hit = make_hit(RES_MAX, RES_MIN, RES_MIN, 0);
        directed_rows[i++].hit = make_hit(RES_MIN, RES_MAX, RES_MIN + 1, 0);
        directed_rows[i++].hit = make_hit(RES_MAX, RES_MIN, RES_MIN + 2, 0);
        directed_rows[i++].hit = make_hit(RES_MIN, RES_MAX, RES_MAX, 0);
        // Skip on the last hit only.
        for (int k = 0; k < PLANES; k++)
            directed_rows[i++].hit = make_hit(-k, k, k, k == PLANES - 1);
        // Extreme z on both ends, bit pattern sweep on x and y.
        directed_rows[i++].hit = make_hit('h55555, 'hAAAAA, RES_MIN, 0);
        directed_rows[i++].hit = make_hit('hAAAAA, 'h55555, RES_MAX, 0);
        directed_rows[i++].hit = make_hit(-1, 0, 0, 0);
        directed_rows[i++].hit = make_hit(0, -1, 1, 0);
    endtask

    // Typed expectations for the first two events: the flat event fails its fit and the
    // event on a straight line has zero residuals.
    task automatic check_typed_beat(int b, lfr_res_t got);
        lfr_res_t want;
        want = '0;
        want.plane_index   = 2'(b % PLANES);
        want.fit_failed    = (b < PLANES);
        want.last_of_event = ((b % PLANES) == PLANES - 1);
        if (got.res_x !== want.res_x) begin
            $error("typed res_x expected %0d got %0d", want.res_x, got.res_x);
            error_count++;
        end
        if (got.res_y !== want.res_y) begin
            $error("typed res_y expected %0d got %0d", want.res_y, got.res_y);
            error_count++;
        end
        if (got.plane_index !== want.plane_index) begin
            $error("typed plane_index expected %0d got %0d",
                   want.plane_index, got.plane_index);
            error_count++;
        end
        if (got.fit_failed !== want.fit_failed) begin
            $error("typed fit_failed expected %0d got %0d", want.fit_failed, got.fit_failed);
            error_count++;
        end
        if (got.last_of_event !== want.last_of_event) begin
            $error("typed last_of_event expected %0d got %0d",
                   want.last_of_event, got.last_of_event);
            error_count++;
        end
    endtask

    // Sender: reset, directed table, then random events with pressure phases.
    initial begin
        lfr_hit_t h;
        int z0;
        int step;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_hit = '0;
        m_ready = 1'b0;
        hits_in_event = 0;
        event_skipped = 1'b0;
        error_count = 0;
        beat_count = 0;
        stimulus_done = 1'b0;
        hold_off = 1'b0;
        quiet_phase = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_directed_rows();
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_hit(directed_rows[r].hit);
        end

        for (int i = 0; i < RANDOM_HITS; i++) begin
            // Receiver stall while the sender keeps offering beats.
            if (i == 100) hold_off = 1'b1;
            if (i == 200) quiet_phase = 1'b1;
            if (i == 280) quiet_phase = 1'b0;
            // Sender pause until the block has drained.
            if (i == 320 && hits_in_event == 0) begin
                pause_sender();
                wait (residual_queue.size() == 0);
                @(posedge aclk);
            end
            if (hits_in_event == 0) begin
                z0 = $urandom_range(0, 60000) - 30000;
                step = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4000);
            end
            if ($urandom_range(9) < 7) begin
                // Track-like hit with small scatter.
                h = make_hit($urandom_range(0, 2000) - 1000 + hits_in_event * 50,
                             $urandom_range(0, 2000) - 1000 - hits_in_event * 30,
                             z0 + hits_in_event * step, $urandom_range(0, 29) == 0);
            end else begin
                h.hit_x = rand_coord();
                h.hit_y = rand_coord();
                h.hit_z = rand_coord();
                h.skip_event = $urandom_range(0, 7) == 0;
            end
            send_hit(h);
        end
        pause_sender();
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, quiet stretch.
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                stall = 0;
                while (stall < 2000) begin
                    @(posedge aclk);
                    stall++;
                end
                hold_off = 1'b0;
            end
            m_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 15);
            @(posedge aclk);
        end
    end

    // Output checker against the oldest expected residual.
    always @(posedge aclk) begin
        lfr_res_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (beat_count < 2 * PLANES) check_typed_beat(beat_count, m_res);
            beat_count++;
            if (residual_queue.size() == 0) begin
                $error("unexpected residual beat: plane_index %0d", m_res.plane_index);
                error_count++;
            end else begin
                exp_res = residual_queue.pop_front();
                if (m_res.res_x !== exp_res.res_x) begin
                    $error("res_x expected %0d got %0d", exp_res.res_x, m_res.res_x);
                    error_count++;
                end
                if (m_res.res_y !== exp_res.res_y) begin
                    $error("res_y expected %0d got %0d", exp_res.res_y, m_res.res_y);
                    error_count++;
                end
                if (m_res.plane_index !== exp_res.plane_index) begin
                    $error("plane_index expected %0d got %0d",
                           exp_res.plane_index, m_res.plane_index);
                    error_count++;
                end
                if (m_res.fit_failed !== exp_res.fit_failed) begin
                    $error("fit_failed expected %0d got %0d",
                           exp_res.fit_failed, m_res.fit_failed);
                    error_count++;
                end
                if (m_res.last_of_event !== exp_res.last_of_event) begin
                    $error("last_of_event expected %0d got %0d",
                           exp_res.last_of_event, m_res.last_of_event);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // End of run: drain, then allow trailing cycles for any stray beat.
    initial begin
        wait (stimulus_done);
        wait (residual_queue.size() == 0);
        repeat (300) @(posedge aclk);
        if (error_count == 0 && residual_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
